/* hw/rtl/ecg_gf_pkg.sv */
// Shared constants, types and a helper function for the ECG gain and FIR filter.
`timescale 1ns / 1ps

package ecg_gf_pkg;

  // Filter geometry and widths
  localparam int TAP_COUNT  = 17;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 13;
  localparam int GAIN_W     = 7;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;  // raw x gain, signed
  localparam int MAG_W      = 22;                     // |raw x gain| < 2^22
  localparam int RECIP_W    = 23;
  localparam int RECIP_SH   = 29;
  localparam int ACC_W      = 31;                     // |sum| < 2^30
  localparam int FILT_SH    = 15;
  localparam int DC_W       = 23;

  // Reciprocal of 100 scaled by 2^29, rounded up; exact for magnitudes below 2^22
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5368710);

  // Lead select codes
  typedef enum logic [1:0] {
    LEAD_I   = 2'd0,
    LEAD_II  = 2'd1,
    LEAD_III = 2'd2,
    LEAD_NONE = 2'd3
  } lead_t;

  localparam lead_t LEAD_RESET = LEAD_II;

  // Symmetric low-pass taps; the newest sample meets tap 0
  typedef logic signed [COEF_W-1:0] coef_t;
  localparam coef_t FIR_COEF [TAP_COUNT] = '{
    -13'sd134, -13'sd220, -13'sd298, -13'sd222, 13'sd187, 13'sd1043, 13'sd2201, 13'sd3204,
    13'sd3585,
    13'sd3204, 13'sd2201, 13'sd1043, 13'sd187, -13'sd222, -13'sd298, -13'sd220, -13'sd134
  };

  // Load enables for the two gain stages
  typedef struct packed {
    logic load_mul;
    logic load_div;
  } gain_ctl_t;

  // Per-lead gain in percent; an unused code passes the sample through
  function automatic logic [GAIN_W-1:0] lead_gain(input lead_t sel);
    logic [GAIN_W-1:0] g;
    case (sel)
      LEAD_I:   g = GAIN_W'(90);
      LEAD_III: g = GAIN_W'(85);
      default:  g = GAIN_W'(100);
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/ecg_gf_gain.sv */
// Two-stage lead gain: multiply by gain, then divide by 100 toward zero.
`timescale 1ns / 1ps

module ecg_gf_gain
  import ecg_gf_pkg::*;
(
  input  logic                       clk,
  input  gain_ctl_t                  ctl,
  input  lead_t                      lead,
  input  logic signed [SAMPLE_W-1:0] raw_in,
  output logic signed [SAMPLE_W-1:0] gained
);

  logic signed [PROD_W-1:0]          prod;
  logic        [MAG_W-1:0]           mag;
  logic        [MAG_W+RECIP_W-1:0]   scaled;
  logic        [SAMPLE_W:0]          quot;
  logic signed [SAMPLE_W:0]          quot_s;

  // Stage one: raw sample times gain
  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      prod <= PROD_W'(raw_in) * PROD_W'($signed({1'b0, lead_gain(lead)}));
    end
  end

  // Stage two: divide magnitude by 100 via reciprocal, restore the sign
  always_comb begin
    mag    = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
    scaled = mag * RECIP_100;
    quot   = (SAMPLE_W+1)'(scaled >> RECIP_SH);
    quot_s = prod[PROD_W-1] ? -$signed(quot) : $signed(quot);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_div) begin
      gained <= quot_s[SAMPLE_W-1:0];
    end
  end

endmodule

/* hw/rtl/ecg_gf_cell.sv */
// One tap cell of the transposed FIR chain: partial sum plus tap product.
`timescale 1ns / 1ps

module ecg_gf_cell
  import ecg_gf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  coef_t                      coef,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic signed [ACC_W-1:0]    sum_in,
  output logic signed [ACC_W-1:0]    sum_out
);

  logic signed [SAMPLE_W+COEF_W-1:0] tap_prod;
  logic signed [ACC_W-1:0]           sum_next;

  // Tap product added to the sum handed on by the older neighbour
  always_comb begin
    tap_prod = x * coef;
    sum_next = sum_in + ACC_W'(tap_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= '0;
    end else if (en) begin
      sum_out <= sum_next;
    end
  end

endmodule

/* hw/rtl/ecg_gain_fir_filter.sv */
// Top level: ECG lead gain, 17-tap low-pass FIR chain and DC baseline tracker.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, ecg_sample               | in
//  output  | out_valid, out_ready, filtered_sample, base- | out
//          | line                                         |
//  config  | cfg_wr_en, cfg_wr_data (lead select)         | in
//
// One beat per cycle sustained while out_ready holds high; each input beat passes
// through the gain multiply, the divide-by-100 reciprocal stage and the tap chain.
// Synchronous reset clears the tap chain (an all-zero history), the baseline
// and the pipeline valids; lead select resets to lead II.
// Each stage moves when the one after it is empty or moving, so a held
// result stalls upstream only once every stage is occupied.
`timescale 1ns / 1ps

module ecg_gain_fir_filter
  import ecg_gf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] ecg_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered_sample,
  output logic signed [SAMPLE_W-1:0] baseline,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data
);

  lead_t                      lead;
  logic                       v_mul, v_div, v_out;
  logic                       rdy_mul, rdy_div, rdy_out;
  logic                       load_chain;
  gain_ctl_t                  gctl;
  logic signed [SAMPLE_W-1:0] gained;
  logic signed [ACC_W-1:0]    sums [TAP_COUNT+1];
  logic signed [DC_W-1:0]     dc_sum;
  logic signed [DC_W-1:0]     dc_adj;
  logic signed [SAMPLE_W-1:0] baseline_next;

  // Lead select register
  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= LEAD_RESET;
    end else if (cfg_wr_en) begin
      lead <= lead_t'(cfg_wr_data);
    end
  end

  // Stage handshake: a stage may load when empty or when its beat moves on
  always_comb begin
    rdy_out    = !v_out || out_ready;
    rdy_div    = !v_div || rdy_out;
    rdy_mul    = !v_mul || rdy_div;
    in_ready   = rdy_mul;
    gctl.load_mul = in_valid && rdy_mul;
    gctl.load_div = v_mul && rdy_div;
    load_chain = v_div && rdy_out;
    out_valid  = v_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_div <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy_mul) v_mul <= in_valid;
      if (rdy_div) v_div <= v_mul;
      if (rdy_out) v_out <= v_div;
    end
  end

  // Gain stages
  ecg_gf_gain u_gain (
    .clk    (clk),
    .ctl    (gctl),
    .lead   (lead),
    .raw_in (ecg_sample),
    .gained (gained)
  );

  // Transposed tap chain; cell 0 holds the finished sum
  assign sums[TAP_COUNT] = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    ecg_gf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (load_chain),
      .coef    (FIR_COEF[k]),
      .x       (gained),
      .sum_in  (sums[k+1]),
      .sum_out (sums[k])
    );
  end

  // Floor shift by 15
  assign filtered_sample = sums[0][ACC_W-1:FILT_SH];

  // Baseline: (b*63 + g)/64, truncated toward zero
  always_comb begin
    dc_sum = (DC_W'(baseline) <<< 6) - DC_W'(baseline) + DC_W'(gained);
    dc_adj = dc_sum[DC_W-1] ? dc_sum + DC_W'(63) : dc_sum;
    baseline_next = SAMPLE_W'(dc_adj >>> 6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
    end else if (load_chain) begin
      baseline <= baseline_next;
    end
  end

endmodule
